// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gtrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtrm_pkg
// Shared field widths and request/result types of the tile rectangle mesher.
// ----------------------------------------------------------------------------
package gtrm_pkg;

	localparam int COL_BITS    = 3;
	localparam int ROW_BITS    = 3;
	localparam int TYPE_W      = 8;
	localparam int SIZE_BITS   = 4;
	localparam int RESULT_CAP  = 64;
	localparam int RES_CNT_W   = $clog2(RESULT_CAP + 1);

	typedef struct packed {
		logic                finish;
		logic [TYPE_W-1:0]   tile_type;
		logic [ROW_BITS-1:0] tile_row;
		logic [COL_BITS-1:0] tile_col;
	} tile_t;

	typedef struct packed {
		logic                 last_rect;
		logic                 none_found;
		logic [TYPE_W-1:0]    rect_type;
		logic [SIZE_BITS-1:0] rect_height;
		logic [SIZE_BITS-1:0] rect_width;
		logic [ROW_BITS-1:0]  rect_row;
		logic [COL_BITS-1:0]  rect_col;
	} rect_t;

endpackage

// ===== hw/rtl/gtrm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtrm_core
// Tile store with per-tile used flag in one single-port-read memory, plus the
// scan / grow / widen sequencer that turns a loaded grid into rectangles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtrm_core #(
	parameter int GRID_COLS = 8,
	parameter int GRID_ROWS = 8,
	parameter int TYPE_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gtrm_pkg::TYPE_W-1:0] empty_type,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  gtrm_pkg::tile_t             in_tile,
	output logic                        res_valid,
	input  logic                        res_ready,
	output gtrm_pkg::rect_t             res
);

	localparam int DEPTH  = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CCNT_W = $clog2(GRID_COLS + 1);
	localparam int RCNT_W = $clog2(GRID_ROWS + 1);
	localparam int WORD_W = TYPE_BITS + 1;

	typedef enum logic [11:0] {
		ST_CLEAR   = 12'b0000_0000_0001,
		ST_IDLE    = 12'b0000_0000_0010,
		ST_SCAN_RD = 12'b0000_0000_0100,
		ST_SCAN_EV = 12'b0000_0000_1000,
		ST_GROW_RD = 12'b0000_0001_0000,
		ST_GROW_EV = 12'b0000_0010_0000,
		ST_CHK_RD  = 12'b0000_0100_0000,
		ST_CHK_EV  = 12'b0000_1000_0000,
		ST_MARK    = 12'b0001_0000_0000,
		ST_FOUND   = 12'b0010_0000_0000,
		ST_EMIT    = 12'b0100_0000_0000,
		ST_LAST    = 12'b1000_0000_0000
	} state_t;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [CCNT_W-1:0] c,
	                                               input logic [RCNT_W-1:0] r);
		return ADDR_W'(c) * ADDR_W'(GRID_ROWS) + ADDR_W'(r);
	endfunction

	state_t                      state_q;
	logic [ADDR_W-1:0]           clr_q;
	logic [CCNT_W-1:0]           b_q;
	logic [CCNT_W-1:0]           ex_q;
	logic [RCNT_W-1:0]           y_q;
	logic [RCNT_W-1:0]           ey_q;
	logic [RCNT_W-1:0]           y2_q;
	logic [TYPE_BITS-1:0]        t0_q;
	logic [gtrm_pkg::RES_CNT_W-1:0] cnt_q;
	logic                        pend_v_q;
	gtrm_pkg::rect_t             pend_q;

	// tile memory: bit TYPE_BITS is the used flag
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [WORD_W-1:0] wdata;

	logic                 rd_used;
	logic [TYPE_BITS-1:0] rd_type;
	logic [TYPE_BITS-1:0] empty_t;
	logic                 match;
	logic                 in_grid;
	logic                 load;

	logic [RCNT_W-1:0] next_row;
	logic              row_wrap;
	logic              col_last;
	logic              ex_last;
	logic              y2_end;
	logic              ey_end;
	state_t            adv_state;
	logic [CCNT_W-1:0] adv_b;
	logic [RCNT_W-1:0] adv_y;
	state_t            wid_state;
	gtrm_pkg::rect_t   cur_rect;
	gtrm_pkg::rect_t   none_rect;

	assign rd_used = rd_q[TYPE_BITS];
	assign rd_type = rd_q[TYPE_BITS-1:0];
	assign empty_t = TYPE_BITS'(empty_type);
	assign match   = !rd_used && (rd_type == t0_q);
	assign in_ready = (state_q == ST_IDLE);
	assign load     = in_valid && in_ready;
	assign in_grid  = (7'(in_tile.tile_col) < 7'(GRID_COLS))
		&& (7'(in_tile.tile_row) < 7'(GRID_ROWS));

	// scan-position advance, shared by skip and rectangle-done paths, plus grow/widen end tests
	always_comb begin
		next_row  = (state_q == ST_FOUND || state_q == ST_EMIT) ? ey_q : y_q + 1'b1;
		row_wrap  = (next_row == RCNT_W'(GRID_ROWS));
		col_last  = ((b_q + 1'b1) == CCNT_W'(GRID_COLS));
		ex_last   = ((ex_q + 1'b1) == CCNT_W'(GRID_COLS));
		y2_end    = ((y2_q + 1'b1) == ey_q);
		ey_end    = ((ey_q + 1'b1) == RCNT_W'(GRID_ROWS));
		adv_state = (row_wrap && col_last) ? ST_LAST : ST_SCAN_RD;
		adv_b     = row_wrap ? b_q + 1'b1 : b_q;
		adv_y     = row_wrap ? '0 : next_row;
		wid_state = col_last ? ST_FOUND : ST_CHK_RD;
	end

	always_comb begin
		cur_rect             = '0;
		cur_rect.rect_col    = gtrm_pkg::COL_BITS'(b_q);
		cur_rect.rect_row    = gtrm_pkg::ROW_BITS'(y_q);
		cur_rect.rect_width  = gtrm_pkg::SIZE_BITS'(ex_q - b_q);
		cur_rect.rect_height = gtrm_pkg::SIZE_BITS'(ey_q - y_q);
		cur_rect.rect_type   = gtrm_pkg::TYPE_W'(t0_q);
		none_rect            = '0;
		none_rect.none_found = 1'b1;
		none_rect.last_rect  = 1'b1;
	end

	always_comb begin
		res_valid = 1'b0;
		res       = pend_q;
		case (state_q)
			ST_EMIT: begin
				res_valid     = 1'b1;
				res.last_rect = 1'b0;
			end
			ST_LAST: begin
				res_valid = 1'b1;
				if (pend_v_q) begin
					res.last_rect = 1'b1;
				end else begin
					res = none_rect;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// memory port control: reads and writes never share a cycle
	always_comb begin
		mem_we = 1'b0;
		waddr  = addr_of(b_q, y_q);
		wdata  = '0;
		mem_re = 1'b0;
		raddr  = addr_of(b_q, y_q);
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
			end
			ST_IDLE: begin
				mem_we = load && in_grid;
				waddr  = addr_of(CCNT_W'(in_tile.tile_col), RCNT_W'(in_tile.tile_row));
				wdata  = {1'b0, TYPE_BITS'(in_tile.tile_type)};
			end
			ST_SCAN_RD: begin
				mem_re = 1'b1;
			end
			ST_SCAN_EV: begin
				// scan has passed this tile: drop its used mark for the next pass
				mem_we = rd_used;
				wdata  = {1'b0, rd_type};
			end
			ST_GROW_RD: begin
				mem_re = 1'b1;
				raddr  = addr_of(b_q, ey_q);
			end
			ST_CHK_RD: begin
				mem_re = 1'b1;
				raddr  = addr_of(ex_q, y2_q);
			end
			ST_MARK: begin
				mem_we = 1'b1;
				waddr  = addr_of(ex_q, y2_q);
				wdata  = {1'b1, t0_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			b_q      <= '0;
			y_q      <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (load && in_tile.finish) begin
						b_q      <= '0;
						y_q      <= '0;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						state_q  <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_EV;
				end
				ST_SCAN_EV: begin
					if (rd_used || rd_type == empty_t) begin
						b_q     <= adv_b;
						y_q     <= adv_y;
						state_q <= adv_state;
					end else begin
						t0_q <= rd_type;
						ey_q <= y_q + 1'b1;
						if (row_wrap) begin
							ex_q    <= b_q + 1'b1;
							y2_q    <= y_q;
							state_q <= wid_state;
						end else begin
							state_q <= ST_GROW_RD;
						end
					end
				end
				ST_GROW_RD: begin
					state_q <= ST_GROW_EV;
				end
				ST_GROW_EV: begin
					if (match && !ey_end) begin
						ey_q    <= ey_q + 1'b1;
						state_q <= ST_GROW_RD;
					end else begin
						if (match) begin
							ey_q <= ey_q + 1'b1;
						end
						ex_q    <= b_q + 1'b1;
						y2_q    <= y_q;
						state_q <= wid_state;
					end
				end
				ST_CHK_RD: begin
					state_q <= ST_CHK_EV;
				end
				ST_CHK_EV: begin
					if (!match) begin
						state_q <= ST_FOUND;
					end else if (y2_end) begin
						y2_q    <= y_q;
						state_q <= ST_MARK;
					end else begin
						y2_q    <= y2_q + 1'b1;
						state_q <= ST_CHK_RD;
					end
				end
				ST_MARK: begin
					if (y2_end) begin
						ex_q    <= ex_q + 1'b1;
						y2_q    <= y_q;
						state_q <= ex_last ? ST_FOUND : ST_CHK_RD;
					end else begin
						y2_q <= y2_q + 1'b1;
					end
				end
				ST_FOUND: begin
					if (cnt_q < gtrm_pkg::RES_CNT_W'(gtrm_pkg::RESULT_CAP)) begin
						cnt_q <= cnt_q + 1'b1;
						if (pend_v_q) begin
							state_q <= ST_EMIT;
						end else begin
							pend_q   <= cur_rect;
							pend_v_q <= 1'b1;
							b_q      <= adv_b;
							y_q      <= adv_y;
							state_q  <= adv_state;
						end
					end else begin
						// past the cap: region stays marked, nothing reported
						b_q     <= adv_b;
						y_q     <= adv_y;
						state_q <= adv_state;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						pend_q  <= cur_rect;
						b_q     <= adv_b;
						y_q     <= adv_y;
						state_q <= adv_state;
					end
				end
				ST_LAST: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_rw_same_cycle, !(mem_we && mem_re), "memory read and write collide")
	`ASSERT_IMPLIES(a_mark_right_of_start, state_q == ST_MARK, (ex_q > b_q) && (y2_q < ey_q), "mark outside widened span")
	`ASSERT_IMPLIES(a_emit_has_pending, state_q == ST_EMIT, pend_v_q, "emit without a pending rectangle")
	`ASSERT_ALWAYS(a_cnt_capped, cnt_q <= gtrm_pkg::RES_CNT_W'(gtrm_pkg::RESULT_CAP), "result count over cap")
	`ASSERT_NEXT(a_last_to_idle, state_q == ST_LAST && res_ready, state_q == ST_IDLE, "pass did not close")

endmodule

// ===== hw/rtl/greedy_tile_rect_mesher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_tile_rect_mesher
// Greedy 2-D rectangle mesher over a loaded tile grid.
// ----------------------------------------------------------------------------
// s_axis loads one tile per request (column, row, type); a request with tlast
// set stores its tile and then runs a meshing pass. m_axis returns one
// rectangle per merged region in column-major scan order, tlast on the last
// one; a pass with no non-empty tile returns one result with tuser set.
// cfg writes the empty tile type; write it only while the block is idle.
// A pass reads the tile memory in scan, grow and column-check steps, each a
// read state followed by an evaluate state, writes the used mark of every tile
// in each widened column and reports each rectangle from a found state.
// s_axis_tready stays low for the whole pass.
// After arst_n releases, a clearing sweep over all GRID_COLS*GRID_ROWS tile
// addresses initializes the tile memory with s_axis_tready low. m_axis has an
// output register; when it is full and m_axis_tready is low, the pass holds.
// ----------------------------------------------------------------------------
module greedy_tile_rect_mesher #(
	parameter int GRID_COLS = 8,
	parameter int GRID_ROWS = 8,
	parameter int TYPE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,      // empty_type
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // tile_col[2:0], tile_row[5:3], tile_type[13:6], pad
	input  logic        s_axis_tlast,  // finish
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // rect_col[2:0], rect_row[5:3], rect_width[9:6],
	                                   // rect_height[13:10], rect_type[21:14], pad
	output logic        m_axis_tuser,  // none_found
	output logic        m_axis_tlast   // last_rect
);

	logic [gtrm_pkg::TYPE_W-1:0] empty_q;
	gtrm_pkg::tile_t             tile;
	gtrm_pkg::rect_t             res;
	logic                        res_valid;
	logic                        res_ready;
	logic                        out_v_q;
	gtrm_pkg::rect_t             out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			empty_q <= cfg_data;
		end
	end

	always_comb begin
		tile.tile_col  = s_axis_tdata[2:0];
		tile.tile_row  = s_axis_tdata[5:3];
		tile.tile_type = s_axis_tdata[13:6];
		tile.finish    = s_axis_tlast;
	end

	gtrm_core #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS),
		.TYPE_BITS (TYPE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty_type (empty_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_tile    (tile),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register: refill when empty or being drained
	assign res_ready = !out_v_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b00, out_q.rect_type, out_q.rect_height, out_q.rect_width,
		out_q.rect_row, out_q.rect_col};
	assign m_axis_tuser  = out_q.none_found;
	assign m_axis_tlast  = out_q.last_rect;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy tile rectangle mesher.
// Loads tile grids over the request stream, predicts the merged rectangles of
// every meshing pass and compares each returned rectangle field by field, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;      // empty_type
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // tile_col[2:0], tile_row[5:3], tile_type[13:6], pad
	logic        s_axis_tlast;  // finish
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // rect_col[2:0], rect_row[5:3], rect_width[9:6],
	                            // rect_height[13:10], rect_type[21:14], pad
	logic        m_axis_tuser;  // none_found
	logic        m_axis_tlast;  // last_rect

	// grid shadow, indexed [column][row]
	logic [7:0]      grid_model [0:7][0:7];
	bit              covered    [0:7][0:7];
	logic [7:0]      empty_code;
	gtrm_pkg::rect_t pending_rects[$];
	int              errors;
	int              tiles_sent;
	bit              calm;

	greedy_tile_rect_mesher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("timeout with %0d rectangles outstanding", pending_rects.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit fits(int c, int r, logic [7:0] t);
		return !covered[c][r] && grid_model[c][r] == t;
	endfunction

	// Column-major greedy scan: grow down the rows, then widen across columns.
	function automatic void mesh_grid();
		int              n;
		int              er;
		int              ec;
		bit              grow;
		logic [7:0]      t;
		gtrm_pkg::rect_t rc;
		n = 0;
		foreach (covered[c, r])
			covered[c][r] = 1'b0;
		for (int c = 0; c < 8; c++) begin
			for (int r = 0; r < 8; r++) begin
				t = grid_model[c][r];
				if (t == empty_code || covered[c][r])
					continue;
				er = r;
				while (er < 8 && fits(c, er, t))
					er++;
				ec = c;
				grow = 1'b1;
				while (grow) begin
					for (int y = r; y < er; y++)
						covered[ec][y] = 1'b1;
					ec++;
					if (ec >= 8)
						break;
					for (int y = r; y < er; y++) begin
						if (!fits(ec, y, t)) begin
							grow = 1'b0;
							break;
						end
					end
				end
				if (n < gtrm_pkg::RESULT_CAP) begin
					rc = '0;
					rc.rect_col    = 3'(c);
					rc.rect_row    = 3'(r);
					rc.rect_width  = 4'(ec - c);
					rc.rect_height = 4'(er - r);
					rc.rect_type   = t;
					pending_rects.insert(pending_rects.size(), rc);
					n++;
				end
			end
		end
		if (n == 0) begin
			rc = '0;
			rc.none_found = 1'b1;
			rc.last_rect  = 1'b1;
			pending_rects.insert(pending_rects.size(), rc);
		end else begin
			rc = pending_rects.pop_back();
			rc.last_rect = 1'b1;
			pending_rects.insert(pending_rects.size(), rc);
		end
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Called at a falling edge; returns at a falling edge with the request still up.
	task automatic send_tile(input logic [2:0] c, input logic [2:0] r, input logic [7:0] t,
	                         input bit fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, t, r, c};
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		grid_model[c][r] = t;
		if (fin)
			mesh_grid();
		tiles_sent++;
		@(negedge clk);
	endtask

	task automatic stop_tiles();
		s_axis_tvalid <= 1'b0;
	endtask

	// Waits until every expected rectangle has arrived; a short settle then covers a trailing load.
	task automatic wait_idle();
		while (pending_rects.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_empty_type(input logic [7:0] v);
		stop_tiles();
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		empty_code = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Every tile gets written here before the first pass reads the grid.
	task automatic test_empty_grid();
		write_empty_type(8'h00);
		for (int c = 0; c < 8; c++)
			for (int r = 0; r < 8; r++)
				send_tile(3'(c), 3'(r), 8'h00, c == 7 && r == 7);
	endtask

	task automatic test_single_tiles();
		send_tile(3'd0, 3'd0, 8'hFF, 1'b1);
		send_tile(3'd7, 3'd7, 8'h01, 1'b1);
		send_tile(3'd3, 3'd5, 8'hAA, 1'b0);
		send_tile(3'd4, 3'd2, 8'h55, 1'b1);
	endtask

	// A 2x2 block next to a column whose segment only half matches.
	task automatic test_block_merge();
		for (int c = 2; c < 4; c++)
			for (int r = 6; r < 8; r++)
				send_tile(3'(c), 3'(r), 8'h80, 1'b0);
		send_tile(3'd4, 3'd6, 8'h80, 1'b0);
		send_tile(3'd4, 3'd7, 8'h81, 1'b1);
	endtask

	task automatic test_empty_type_extremes();
		write_empty_type(8'hFF);
		send_tile(3'd0, 3'd0, 8'hFF, 1'b1);
		write_empty_type(8'h80);
		send_tile(3'd5, 3'd0, 8'h80, 1'b1);
	endtask

	task automatic test_random_passes();
		int         first;
		int         passes;
		int         style;
		int         n;
		int         c0;
		int         r0;
		int         w;
		int         h;
		logic [7:0] pal [0:2];
		first  = tiles_sent;
		passes = 0;
		foreach (pal[k])
			pal[k] = pick_type();
		while (tiles_sent - first < 330) begin
			if (passes % 6 == 5) begin
				case ($urandom_range(0, 3))
					0: write_empty_type(8'h00);
					1: write_empty_type(8'hFF);
					2: write_empty_type(8'($urandom_range(0, 255)));
					default: write_empty_type(pal[0]);
				endcase
			end
			calm = ($urandom_range(0, 3) == 0);
			foreach (pal[k])
				pal[k] = pick_type();
			if ($urandom_range(0, 7) == 0) begin
				// hold off until the previous pass has fully drained
				stop_tiles();
				wait_idle();
			end
			style = $urandom_range(0, 9);
			if (style == 9) begin
				if (pal[1] == pal[0])
					pal[1] = ~pal[0];
				for (int c = 0; c < 8; c++)
					for (int r = 0; r < 8; r++)
						send_tile(3'(c), 3'(r), pal[(c + r) % 2], c == 7 && r == 7);
			end else if (style <= 4) begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					send_tile(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					          pal[$urandom_range(0, 2)], i == n - 1);
			end else if (style <= 7) begin
				c0 = $urandom_range(0, 7);
				r0 = $urandom_range(0, 7);
				w  = $urandom_range(1, (8 - c0) < 4 ? 8 - c0 : 4);
				h  = $urandom_range(1, (8 - r0) < 4 ? 8 - r0 : 4);
				for (int c = c0; c < c0 + w; c++)
					for (int r = r0; r < r0 + h; r++)
						send_tile(3'(c), 3'(r), pal[0],
						          c == c0 + w - 1 && r == r0 + h - 1);
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_tile(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					          pal[$urandom_range(0, 2)], 1'b1);
			end
			passes++;
		end
		calm = 1'b0;
	endtask

	// Result side: draw a stall before each result, then take it.
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		gtrm_pkg::rect_t want;
		gtrm_pkg::rect_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tlast, m_axis_tuser, m_axis_tdata[21:0]};
			if (pending_rects.size() == 0) begin
				errors++;
				$display("%0t: unexpected rectangle, expected none, got %h", $time, got);
			end else begin
				want = pending_rects.pop_front();
				check_field("rect_col",    32'(want.rect_col),    32'(got.rect_col));
				check_field("rect_row",    32'(want.rect_row),    32'(got.rect_row));
				check_field("rect_width",  32'(want.rect_width),  32'(got.rect_width));
				check_field("rect_height", 32'(want.rect_height), 32'(got.rect_height));
				check_field("rect_type",   32'(want.rect_type),   32'(got.rect_type));
				check_field("none_found",  32'(want.none_found),  32'(got.none_found));
				check_field("last_rect",   32'(want.last_rect),   32'(got.last_rect));
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		empty_code    = '0;
		errors        = 0;
		tiles_sent    = 0;
		calm          = 1'b0;
		foreach (grid_model[c, r])
			grid_model[c][r] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_grid();
		test_single_tiles();
		test_block_merge();
		test_empty_type_extremes();
		test_random_passes();

		stop_tiles();
		while (pending_rects.size() != 0)
			@(negedge clk);
		// catch any stray rectangles after the last pass
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
